>>> sv/line_segment_window_clipper_macros.svh
// Assertion macros used by the checker of the line segment window clipper.
// Depends on nothing; included by lswc_checker, which holds the concurrent assertions.
`ifndef LINE_SEGMENT_WINDOW_CLIPPER_MACROS_SVH
`define LINE_SEGMENT_WINDOW_CLIPPER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define LSWC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lswc same-cycle assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define LSWC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lswc next-cycle assertion failed");

`endif

>>> sv/lswc_pkg.sv
// Line segment window clipper package: state type, region bits, register indexes,
// reset window and pass limit. Depends on nothing; used by the top level and the testbench.
`timescale 1ns / 1ps

package lswc_pkg;

   // Region code bits of an endpoint.
   localparam logic [3:0] REG_TOP    = 4'd8;
   localparam logic [3:0] REG_BOTTOM = 4'd4;
   localparam logic [3:0] REG_RIGHT  = 4'd2;
   localparam logic [3:0] REG_LEFT   = 4'd1;
   localparam logic [3:0] REG_NONE   = 4'd0;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_MIN = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_MAX = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_MIN = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_MAX = 4'd3;

   // Window values after reset.
   localparam int WIN_X_MIN_RESET = 0;
   localparam int WIN_X_MAX_RESET = 639;
   localparam int WIN_Y_MIN_RESET = 0;
   localparam int WIN_Y_MAX_RESET = 479;
   // Signed width that holds every reset value.
   localparam int WIN_RESET_WIDTH = 11;

   // Clipping passes before a segment is given up as rejected.
   localparam int CLIP_PASS_LIMIT = 16;
   localparam int PASS_CNT_WIDTH  = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MUL,
      ST_DIV,
      ST_FIX,
      ST_FINISH
   } state_type;

endpackage

>>> sv/lswc_req_if.sv
// Request channel of the line segment window clipper: one segment per request.
// Depends on nothing.
`timescale 1ns / 1ps

interface lswc_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

>>> sv/lswc_rsp_if.sv
// Result channel of the line segment window clipper: one clipped segment per request.
// Depends on nothing.
`timescale 1ns / 1ps

interface lswc_rsp_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic signed [COORD_WIDTH-1:0] clipped_start_x;
   logic signed [COORD_WIDTH-1:0] clipped_start_y;
   logic signed [COORD_WIDTH-1:0] clipped_end_x;
   logic signed [COORD_WIDTH-1:0] clipped_end_y;
   logic [3:0]                    start_region;
   logic [3:0]                    end_region;

   modport source (output valid, accepted, clipped_start_x, clipped_start_y, clipped_end_x,
                   clipped_end_y, start_region, end_region, input ready);
   modport sink   (input valid, accepted, clipped_start_x, clipped_start_y, clipped_end_x,
                   clipped_end_y, start_region, end_region, output ready);
endinterface

>>> sv/lswc_csr_if.sv
// Configuration write channel of the line segment window clipper.
// Depends on nothing.
`timescale 1ns / 1ps

interface lswc_csr_if #(parameter int COORD_WIDTH = 16, parameter int INDEX_WIDTH = 4);
   logic                          valid;
   logic                          ready;
   logic [INDEX_WIDTH-1:0]        index;
   logic signed [COORD_WIDTH-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/line_segment_window_clipper.sv
// Line segment window clipper (Cohen-Sutherland). A request carries two endpoints; the block
// answers with one result: an accepted flag, the clipped endpoints (zero when rejected) and the
// region codes of the original endpoints (top 8, bottom 4, right 2, left 1; border points are
// inside). The window is set through four configuration registers: 0 x min, 1 x max,
// 2 y min, 3 y max; writes to other indexes are ignored and the port is always ready.
// One request is worked on at a time and the request side is not ready meanwhile. Each clipping
// pass runs through a decision state, one multiply state, the division states of a shared
// restoring divider producing one quotient bit per cycle, and a state that writes the new
// endpoint. After acceptance a request makes P clipping passes and a final decision before
// its result is offered, where P is the number of clipping passes (0 to 4 for a proper
// window, up to 16 for an inverted one). The request side is ready again in the cycle the
// result is offered. The result sits in an output register, so a new request is taken
// while the previous result still waits for the consumer; the block stalls only when a
// second result is done before the first one is taken.
// Depends on lswc_pkg and the lswc_req_if, lswc_rsp_if and lswc_csr_if interfaces.
`timescale 1ns / 1ps

module line_segment_window_clipper #(
   parameter int COORD_WIDTH = 16
) (
   input logic        clock,
   input logic        reset,
   lswc_csr_if.sink   csr_bus,
   lswc_req_if.sink   req_bus,
   lswc_rsp_if.source rsp_bus
);

   localparam int CW = COORD_WIDTH;
   // The window registers must hold the reset values even for narrow coordinates.
   localparam int WIN_W = (CW > lswc_pkg::WIN_RESET_WIDTH) ? CW : lswc_pkg::WIN_RESET_WIDTH;
   localparam int STEP_W = $clog2(CW);
   localparam int PW = lswc_pkg::PASS_CNT_WIDTH;

   // Magnitude of a difference; every difference here fits CW bits of magnitude.
   function automatic logic [CW-1:0] mag(input logic signed [CW:0] v);
      logic signed [CW:0] n;
      n = -v;
      return v[CW] ? n[CW-1:0] : v[CW-1:0];
   endfunction

   // Window registers.
   logic signed [WIN_W-1:0] win_x_min_ff, win_x_max_ff, win_y_min_ff, win_y_max_ff;

   // Sequencer and working registers.
   lswc_pkg::state_type state_ff, state_in;
   logic signed [CW-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic signed [CW-1:0] x0_in, y0_in, x1_in, y1_in;
   logic [3:0]           r0_ff, r1_ff, r0_in, r1_in;
   logic [PW-1:0]        pass_ff, pass_in;
   logic [CW-1:0]        ma_ff, mb_ff, md_ff, ma_in, mb_in, md_in;
   logic                 neg_ff, neg_in;
   logic signed [CW-1:0] base_ff, base_in;
   logic signed [CW-1:0] bound_ff, bound_in;
   logic                 sel_end_ff, sel_end_in;
   logic                 horiz_ff, horiz_in;
   logic [2*CW-1:0]      prod_ff, prod_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 acc_ff, acc_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_acc_ff, rsp_acc_in;
   logic signed [CW-1:0] rsp_sx_ff, rsp_sy_ff, rsp_ex_ff, rsp_ey_ff;
   logic signed [CW-1:0] rsp_sx_in, rsp_sy_in, rsp_ex_in, rsp_ey_in;
   logic [3:0]           rsp_sreg_ff, rsp_ereg_ff, rsp_sreg_in, rsp_ereg_in;

   // Region codes of the current endpoints; the border counts as inside.
   logic signed [WIN_W-1:0] x0_w, y0_w, x1_w, y1_w;
   logic [3:0]              c0, c1, csel;
   assign x0_w = WIN_W'(x0_ff);
   assign y0_w = WIN_W'(y0_ff);
   assign x1_w = WIN_W'(x1_ff);
   assign y1_w = WIN_W'(y1_ff);

   assign c0 = ((y0_w > win_y_max_ff) ? lswc_pkg::REG_TOP    : lswc_pkg::REG_NONE) |
               ((y0_w < win_y_min_ff) ? lswc_pkg::REG_BOTTOM : lswc_pkg::REG_NONE) |
               ((x0_w > win_x_max_ff) ? lswc_pkg::REG_RIGHT  : lswc_pkg::REG_NONE) |
               ((x0_w < win_x_min_ff) ? lswc_pkg::REG_LEFT   : lswc_pkg::REG_NONE);
   assign c1 = ((y1_w > win_y_max_ff) ? lswc_pkg::REG_TOP    : lswc_pkg::REG_NONE) |
               ((y1_w < win_y_min_ff) ? lswc_pkg::REG_BOTTOM : lswc_pkg::REG_NONE) |
               ((x1_w > win_x_max_ff) ? lswc_pkg::REG_RIGHT  : lswc_pkg::REG_NONE) |
               ((x1_w < win_x_min_ff) ? lswc_pkg::REG_LEFT   : lswc_pkg::REG_NONE);

   // The first outside endpoint is clipped, the start point before the end point.
   assign csel = (c0 != lswc_pkg::REG_NONE) ? c0 : c1;

   // Edge selection and operand set-up of the next pass. The chosen edge always lies
   // between the two endpoints, so it fits the coordinate width whenever it is used.
   logic                 clip_horiz;
   logic signed [CW-1:0] bound_sel;
   logic signed [CW:0]   dx, dy, num, den, off;
   always_comb begin
      clip_horiz = (csel & (lswc_pkg::REG_TOP | lswc_pkg::REG_BOTTOM)) != lswc_pkg::REG_NONE;
      if ((csel & lswc_pkg::REG_TOP) != lswc_pkg::REG_NONE) begin
         bound_sel = win_y_max_ff[CW-1:0];
      end else if ((csel & lswc_pkg::REG_BOTTOM) != lswc_pkg::REG_NONE) begin
         bound_sel = win_y_min_ff[CW-1:0];
      end else if ((csel & lswc_pkg::REG_RIGHT) != lswc_pkg::REG_NONE) begin
         bound_sel = win_x_max_ff[CW-1:0];
      end else begin
         bound_sel = win_x_min_ff[CW-1:0];
      end
      dx  = (CW+1)'(x1_ff) - (CW+1)'(x0_ff);
      dy  = (CW+1)'(y1_ff) - (CW+1)'(y0_ff);
      num = clip_horiz ? dx : dy;
      den = clip_horiz ? dy : dx;
      off = (CW+1)'(bound_sel) - (clip_horiz ? (CW+1)'(y0_ff) : (CW+1)'(x0_ff));
   end

   // Shared multiplier, used once per pass.
   logic [2*CW-1:0] mul_res;
   assign mul_res = (2*CW)'(ma_ff) * (2*CW)'(mb_ff);

   // One restoring division step: the upper half of prod_ff is the partial remainder and the
   // quotient bits shift into the lower half.
   logic [CW:0]   div_trial, div_diff;
   logic          div_ge;
   logic [CW-1:0] div_rem;
   always_comb begin
      div_trial = {prod_ff[2*CW-1:CW], prod_ff[CW-1]};
      div_ge    = div_trial >= {1'b0, md_ff};
      div_diff  = div_trial - {1'b0, md_ff};
      div_rem   = div_ge ? div_diff[CW-1:0] : div_trial[CW-1:0];
   end

   // New coordinate: start point coordinate plus the signed, truncated quotient.
   logic [CW:0]          quot_ext, quot_neg;
   logic signed [CW:0]   new_sum;
   logic signed [CW-1:0] new_coord;
   always_comb begin
      quot_ext  = {1'b0, prod_ff[CW-1:0]};
      quot_neg  = -quot_ext;
      new_sum   = (CW+1)'(base_ff) + $signed(neg_ff ? quot_neg : quot_ext);
      new_coord = new_sum[CW-1:0];
   end

   logic req_fire, rsp_fire, rsp_free;
   logic req_ready_int;
   assign req_ready_int = (state_ff == lswc_pkg::ST_IDLE);
   assign req_bus.ready = req_ready_int;
   assign req_fire = req_bus.valid && req_ready_int;
   assign rsp_fire = rsp_valid_ff && rsp_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // Sequencer: next state and datapath loads.
   always_comb begin
      state_in    = state_ff;
      x0_in       = x0_ff;
      y0_in       = y0_ff;
      x1_in       = x1_ff;
      y1_in       = y1_ff;
      r0_in       = r0_ff;
      r1_in       = r1_ff;
      pass_in     = pass_ff;
      ma_in       = ma_ff;
      mb_in       = mb_ff;
      md_in       = md_ff;
      neg_in      = neg_ff;
      base_in     = base_ff;
      bound_in    = bound_ff;
      sel_end_in  = sel_end_ff;
      horiz_in    = horiz_ff;
      prod_in     = prod_ff;
      step_in     = step_ff;
      acc_in      = acc_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_acc_in  = rsp_acc_ff;
      rsp_sx_in   = rsp_sx_ff;
      rsp_sy_in   = rsp_sy_ff;
      rsp_ex_in   = rsp_ex_ff;
      rsp_ey_in   = rsp_ey_ff;
      rsp_sreg_in = rsp_sreg_ff;
      rsp_ereg_in = rsp_ereg_ff;
      case (state_ff)
         lswc_pkg::ST_IDLE: begin
            if (req_fire) begin
               x0_in    = req_bus.start_x;
               y0_in    = req_bus.start_y;
               x1_in    = req_bus.end_x;
               y1_in    = req_bus.end_y;
               pass_in  = '0;
               state_in = lswc_pkg::ST_DECIDE;
            end
         end
         lswc_pkg::ST_DECIDE: begin
            // The codes seen before the first pass are those of the original endpoints.
            if (pass_ff == '0) begin
               r0_in = c0;
               r1_in = c1;
            end
            if ((c0 | c1) == lswc_pkg::REG_NONE) begin
               acc_in   = 1'b1;
               state_in = lswc_pkg::ST_FINISH;
            end else if (((c0 & c1) != lswc_pkg::REG_NONE) ||
                         (pass_ff == PW'(lswc_pkg::CLIP_PASS_LIMIT))) begin
               acc_in   = 1'b0;
               state_in = lswc_pkg::ST_FINISH;
            end else begin
               ma_in      = mag(num);
               mb_in      = mag(off);
               md_in      = mag(den);
               neg_in     = num[CW] ^ off[CW] ^ den[CW];
               base_in    = clip_horiz ? x0_ff : y0_ff;
               bound_in   = bound_sel;
               sel_end_in = (c0 == lswc_pkg::REG_NONE);
               horiz_in   = clip_horiz;
               state_in   = lswc_pkg::ST_MUL;
            end
         end
         lswc_pkg::ST_MUL: begin
            prod_in  = mul_res;
            step_in  = '0;
            state_in = lswc_pkg::ST_DIV;
         end
         lswc_pkg::ST_DIV: begin
            prod_in = {div_rem, prod_ff[CW-2:0], div_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CW - 1)) begin
               state_in = lswc_pkg::ST_FIX;
            end
         end
         lswc_pkg::ST_FIX: begin
            if (sel_end_ff) begin
               x1_in = horiz_ff ? new_coord : bound_ff;
               y1_in = horiz_ff ? bound_ff : new_coord;
            end else begin
               x0_in = horiz_ff ? new_coord : bound_ff;
               y0_in = horiz_ff ? bound_ff : new_coord;
            end
            pass_in  = pass_ff + 1'b1;
            state_in = lswc_pkg::ST_DECIDE;
         end
         lswc_pkg::ST_FINISH: begin
            // Wait until the output register is free or being emptied.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               rsp_sx_in    = acc_ff ? x0_ff : '0;
               rsp_sy_in    = acc_ff ? y0_ff : '0;
               rsp_ex_in    = acc_ff ? x1_ff : '0;
               rsp_ey_in    = acc_ff ? y1_ff : '0;
               rsp_sreg_in  = r0_ff;
               rsp_ereg_in  = r1_ff;
               state_in     = lswc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lswc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lswc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      r0_ff       <= r0_in;
      r1_ff       <= r1_in;
      pass_ff     <= pass_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      md_ff       <= md_in;
      neg_ff      <= neg_in;
      base_ff     <= base_in;
      bound_ff    <= bound_in;
      sel_end_ff  <= sel_end_in;
      horiz_ff    <= horiz_in;
      prod_ff     <= prod_in;
      step_ff     <= step_in;
      acc_ff      <= acc_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_sx_ff   <= rsp_sx_in;
      rsp_sy_ff   <= rsp_sy_in;
      rsp_ex_ff   <= rsp_ex_in;
      rsp_ey_ff   <= rsp_ey_in;
      rsp_sreg_ff <= rsp_sreg_in;
      rsp_ereg_ff <= rsp_ereg_in;
   end

   // Configuration registers; written data is sign-extended to the register width.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_x_min_ff <= WIN_W'(lswc_pkg::WIN_X_MIN_RESET);
         win_x_max_ff <= WIN_W'(lswc_pkg::WIN_X_MAX_RESET);
         win_y_min_ff <= WIN_W'(lswc_pkg::WIN_Y_MIN_RESET);
         win_y_max_ff <= WIN_W'(lswc_pkg::WIN_Y_MAX_RESET);
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            lswc_pkg::CSR_X_MIN: win_x_min_ff <= WIN_W'(csr_bus.data);
            lswc_pkg::CSR_X_MAX: win_x_max_ff <= WIN_W'(csr_bus.data);
            lswc_pkg::CSR_Y_MIN: win_y_min_ff <= WIN_W'(csr_bus.data);
            lswc_pkg::CSR_Y_MAX: win_y_max_ff <= WIN_W'(csr_bus.data);
            default: begin
            end
         endcase
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.accepted        = rsp_acc_ff;
   assign rsp_bus.clipped_start_x = rsp_sx_ff;
   assign rsp_bus.clipped_start_y = rsp_sy_ff;
   assign rsp_bus.clipped_end_x   = rsp_ex_ff;
   assign rsp_bus.clipped_end_y   = rsp_ey_ff;
   assign rsp_bus.start_region    = rsp_sreg_ff;
   assign rsp_bus.end_region      = rsp_ereg_ff;

endmodule

>>> sv/lswc_checker.sv
// Port-level checker of the line segment window clipper and its bind to the top level.
// Depends on line_segment_window_clipper_macros.svh and line_segment_window_clipper.
`timescale 1ns / 1ps
`include "line_segment_window_clipper_macros.svh"

module lswc_checker #(
   parameter int COORD_WIDTH = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_accepted,
   input logic [COORD_WIDTH-1:0] rsp_clipped_start_x,
   input logic [COORD_WIDTH-1:0] rsp_clipped_start_y,
   input logic [COORD_WIDTH-1:0] rsp_clipped_end_x,
   input logic [COORD_WIDTH-1:0] rsp_clipped_end_y,
   input logic [3:0]             rsp_start_region,
   input logic [3:0]             rsp_end_region
);

   // A pending result is never withdrawn.
   `LSWC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Once a request is taken the block is busy for at least the next cycle.
   `LSWC_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // A rejected segment carries zero endpoints.
   `LSWC_ASSERT_IMP(a_reject_zero, clock, reset, rsp_valid && !rsp_accepted, (rsp_clipped_start_x == '0) && (rsp_clipped_start_y == '0) && (rsp_clipped_end_x == '0) && (rsp_clipped_end_y == '0))

   // Endpoints sharing an outside region can never be accepted.
   `LSWC_ASSERT_IMP(a_trivial_reject, clock, reset, rsp_valid && rsp_accepted, (rsp_start_region & rsp_end_region) == 4'd0)

endmodule

bind line_segment_window_clipper lswc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lswc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_bus.valid),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_accepted        (rsp_bus.accepted),
   .rsp_clipped_start_x (rsp_bus.clipped_start_x),
   .rsp_clipped_start_y (rsp_bus.clipped_start_y),
   .rsp_clipped_end_x   (rsp_bus.clipped_end_x),
   .rsp_clipped_end_y   (rsp_bus.clipped_end_y),
   .rsp_start_region    (rsp_bus.start_region),
   .rsp_end_region      (rsp_bus.end_region)
);

>>> dv/line_segment_window_clipper_test.sv
// Testbench of the line segment window clipper: clips segments against several windows and checks
// every result against a predictor kept inside a small scoreboard class.
// Depends on lswc_pkg, the lswc_req_if, lswc_rsp_if and lswc_csr_if interfaces and the top level.
`timescale 1ns / 1ps

module line_segment_window_clipper_test;

   localparam int COORD_WIDTH = 16;
   localparam int COORD_MAX = 2 ** (COORD_WIDTH - 1) - 1;
   localparam int COORD_MIN = -COORD_MAX - 1;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLDOFF_CYCLES = 400;
   // Idle wait at the end of the run, after the last result has come back.
   localparam int DRAIN_CYCLES = 100;
   localparam int DIRECTED_COUNT = 24;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] start_x;
      logic signed [COORD_WIDTH-1:0] start_y;
      logic signed [COORD_WIDTH-1:0] end_x;
      logic signed [COORD_WIDTH-1:0] end_y;
   } segment_type;

   typedef struct packed {
      logic                          accepted;
      logic signed [COORD_WIDTH-1:0] clipped_start_x;
      logic signed [COORD_WIDTH-1:0] clipped_start_y;
      logic signed [COORD_WIDTH-1:0] clipped_end_x;
      logic signed [COORD_WIDTH-1:0] clipped_end_y;
      logic [3:0]                    start_region;
      logic [3:0]                    end_region;
   } clip_type;

   typedef enum {SINK_STEADY, SINK_RANDOM, SINK_PATTERN} sink_mode_type;

   // The scoreboard keeps its own copy of the window and computes the clipped segment for
   // every request the block takes. Results must come back in request order.
   class clip_scoreboard;
      longint   win_x_min, win_x_max, win_y_min, win_y_max;
      clip_type expected_clips[$];
      int       failures;

      function new();
         win_x_min = lswc_pkg::WIN_X_MIN_RESET;
         win_x_max = lswc_pkg::WIN_X_MAX_RESET;
         win_y_min = lswc_pkg::WIN_Y_MIN_RESET;
         win_y_max = lswc_pkg::WIN_Y_MAX_RESET;
         failures  = 0;
      endfunction

      function void write_window(logic [lswc_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 logic signed [COORD_WIDTH-1:0] data);
         case (index)
            lswc_pkg::CSR_X_MIN: win_x_min = data;
            lswc_pkg::CSR_X_MAX: win_x_max = data;
            lswc_pkg::CSR_Y_MIN: win_y_min = data;
            lswc_pkg::CSR_Y_MAX: win_y_max = data;
            default: ;
         endcase
      endfunction

      function logic [3:0] region_of(longint x, longint y);
         logic [3:0] code = lswc_pkg::REG_NONE;
         if (y > win_y_max) code |= lswc_pkg::REG_TOP;
         if (y < win_y_min) code |= lswc_pkg::REG_BOTTOM;
         if (x > win_x_max) code |= lswc_pkg::REG_RIGHT;
         if (x < win_x_min) code |= lswc_pkg::REG_LEFT;
         return code;
      endfunction

      // Exact product, quotient truncated toward zero; a zero divisor gives zero.
      function longint scaled_offset(longint num, longint off, longint den);
         if (den == 0) return 0;
         return (num * off) / den;
      endfunction

      function clip_type clip_segment(segment_type s);
         longint     x0, y0, x1, y1, nx, ny;
         logic [3:0] c0, c1, code;
         clip_type   r;
         x0 = s.start_x;
         y0 = s.start_y;
         x1 = s.end_x;
         y1 = s.end_y;
         c0 = region_of(x0, y0);
         c1 = region_of(x1, y1);
         r = '0;
         r.start_region = c0;
         r.end_region = c1;
         for (int pass = 0; pass <= lswc_pkg::CLIP_PASS_LIMIT; pass++) begin
            if ((c0 | c1) == lswc_pkg::REG_NONE) begin
               r.accepted = 1'b1;
               r.clipped_start_x = x0[COORD_WIDTH-1:0];
               r.clipped_start_y = y0[COORD_WIDTH-1:0];
               r.clipped_end_x = x1[COORD_WIDTH-1:0];
               r.clipped_end_y = y1[COORD_WIDTH-1:0];
               return r;
            end
            if ((c0 & c1) != lswc_pkg::REG_NONE || pass == lswc_pkg::CLIP_PASS_LIMIT) break;
            // The first outside endpoint moves; edges are taken top, bottom, right, left.
            code = (c0 != lswc_pkg::REG_NONE) ? c0 : c1;
            if ((code & lswc_pkg::REG_TOP) != lswc_pkg::REG_NONE) begin
               ny = win_y_max;
               nx = x0 + scaled_offset(x1 - x0, win_y_max - y0, y1 - y0);
            end else if ((code & lswc_pkg::REG_BOTTOM) != lswc_pkg::REG_NONE) begin
               ny = win_y_min;
               nx = x0 + scaled_offset(x1 - x0, win_y_min - y0, y1 - y0);
            end else if ((code & lswc_pkg::REG_RIGHT) != lswc_pkg::REG_NONE) begin
               nx = win_x_max;
               ny = y0 + scaled_offset(y1 - y0, win_x_max - x0, x1 - x0);
            end else begin
               nx = win_x_min;
               ny = y0 + scaled_offset(y1 - y0, win_x_min - x0, x1 - x0);
            end
            if (c0 != lswc_pkg::REG_NONE) begin
               x0 = nx;
               y0 = ny;
               c0 = region_of(x0, y0);
            end else begin
               x1 = nx;
               y1 = ny;
               c1 = region_of(x1, y1);
            end
         end
         return r;
      endfunction

      function void note_segment(segment_type s);
         expected_clips.push_back(clip_segment(s));
      endfunction

      function int pending();
         return expected_clips.size();
      endfunction

      function void compare_field(string field, longint want, longint got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            failures++;
         end
      endfunction

      function void check_result(clip_type got);
         clip_type want;
         if (expected_clips.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            failures++;
            return;
         end
         want = expected_clips.pop_front();
         compare_field("accepted", want.accepted, got.accepted);
         compare_field("clipped_start_x", want.clipped_start_x, got.clipped_start_x);
         compare_field("clipped_start_y", want.clipped_start_y, got.clipped_start_y);
         compare_field("clipped_end_x", want.clipped_end_x, got.clipped_end_x);
         compare_field("clipped_end_y", want.clipped_end_y, got.clipped_end_y);
         compare_field("start_region", want.start_region, got.start_region);
         compare_field("end_region", want.end_region, got.end_region);
      endfunction
   endclass

   logic clock;
   logic reset;

   lswc_req_if #(.COORD_WIDTH(COORD_WIDTH)) req_bus ();
   lswc_rsp_if #(.COORD_WIDTH(COORD_WIDTH)) rsp_bus ();
   lswc_csr_if #(.COORD_WIDTH(COORD_WIDTH), .INDEX_WIDTH(lswc_pkg::CSR_INDEX_WIDTH)) csr_bus ();

   line_segment_window_clipper #(.COORD_WIDTH(COORD_WIDTH)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   clip_scoreboard sb = new();

   // Receiver controls: the stimulus sets them, the receiver reads them and counts served hold-offs.
   sink_mode_type sink_mode = SINK_RANDOM;
   int            holdoff_requests = 0;
   int            holdoffs_served = 0;
   // Requests left in the current burst of the sender.
   int            burst_left = 0;
   int            cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Everything that crosses a handshake is sampled here, at the rising edge, before the
   // block's own registers move. Inputs only change at the falling edge, so there is no race.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) sb.write_window(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready) begin
            sb.note_segment('{req_bus.start_x, req_bus.start_y, req_bus.end_x, req_bus.end_y});
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result('{rsp_bus.accepted, rsp_bus.clipped_start_x, rsp_bus.clipped_start_y,
                              rsp_bus.clipped_end_x, rsp_bus.clipped_end_y,
                              rsp_bus.start_region, rsp_bus.end_region});
         end
      end
   end

   // A run that hangs anywhere (lost result, stuck ready) ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("line_segment_window_clipper test failed");
         $finish;
      end
   end

   // Receiver: it stalls according to the current sink mode. A hold-off request makes it
   // refuse results for a long stretch, so the output register fills and the block stops
   // taking requests while the sender keeps offering them.
   initial begin
      int stall_left;
      int tick;
      stall_left = 0;
      tick = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (holdoffs_served != holdoff_requests) begin
            holdoffs_served++;
            stall_left = HOLDOFF_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            case (sink_mode)
               SINK_STEADY:  rsp_bus.ready = 1'b1;
               SINK_RANDOM:  rsp_bus.ready = ($urandom_range(0, 9) < 7);
               SINK_PATTERN: rsp_bus.ready = ((tick % 11) >= 4);
               default:      rsp_bus.ready = 1'b1;
            endcase
         end
      end
   end

   function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(int v);
      if (v > COORD_MAX) return COORD_WIDTH'(COORD_MAX);
      if (v < COORD_MIN) return COORD_WIDTH'(COORD_MIN);
      return COORD_WIDTH'(v);
   endfunction

   // A coordinate near the window most of the time, on or just beside an edge often, and
   // anywhere in the full range now and then so that every bit toggles.
   function automatic logic signed [COORD_WIDTH-1:0] pick_coord(int lo, int hi);
      int a, b, v;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      case ($urandom_range(0, 3))
         0: v = int'($urandom_range(0, 65535)) + COORD_MIN;
         1, 2: v = a - 64 + int'($urandom_range(0, b - a + 128));
         default: begin
            case ($urandom_range(0, 3))
               0: v = a - 1;
               1: v = a;
               2: v = b;
               default: v = b + 1;
            endcase
         end
      endcase
      return clamp_coord(v);
   endfunction

   // Offers one request and returns at the edge where it is taken. Valid stays high so that
   // back-to-back requests go out without a bubble; a burst ends with a random gap.
   task automatic offer_segment(segment_type s, bit bursty);
      int gap;
      if (bursty && burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.start_x = s.start_x;
      req_bus.start_y = s.start_y;
      req_bus.end_x = s.end_x;
      req_bus.end_y = s.end_y;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (burst_left > 0) burst_left--;
   endtask

   // The sender pauses until every result has come back; the block is idle afterwards.
   task automatic wait_for_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_window_reg(logic [lswc_pkg::CSR_INDEX_WIDTH-1:0] index, int value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = index;
      csr_bus.data = clamp_coord(value);
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic set_window(int x_lo, int x_hi, int y_lo, int y_hi);
      write_window_reg(lswc_pkg::CSR_X_MIN, x_lo);
      write_window_reg(lswc_pkg::CSR_X_MAX, x_hi);
      write_window_reg(lswc_pkg::CSR_Y_MIN, y_lo);
      write_window_reg(lswc_pkg::CSR_Y_MAX, y_hi);
   endtask

   task automatic run_random(int count, bit bursty);
      segment_type s;
      for (int i = 0; i < count; i++) begin
         s.start_x = pick_coord(int'(sb.win_x_min), int'(sb.win_x_max));
         s.start_y = pick_coord(int'(sb.win_y_min), int'(sb.win_y_max));
         s.end_x = pick_coord(int'(sb.win_x_min), int'(sb.win_x_max));
         s.end_y = pick_coord(int'(sb.win_y_min), int'(sb.win_y_max));
         offer_segment(s, bursty);
      end
   endtask

   // Directed segments against the reset window (x 0..639, y 0..479): fully inside, on the
   // border, trivially rejected on each side, crossing each edge, crossing two window sides, passing
   // beside a corner, points just outside, degenerate points, and the coordinate extremes.
   int directed_cases [DIRECTED_COUNT][4] = '{
      '{10, 10, 600, 400},        '{0, 0, 639, 479},          '{-100, 10, -5, 400},
      '{100, 480, 500, 900},      '{100, 100, 200, 600},      '{300, -50, 320, 200},
      '{500, 200, 900, 260},      '{-300, 50, 100, 300},      '{-100, -100, 800, 600},
      '{-100, 400, 100, 700},     '{-32768, -32768, 32767, 32767},
      '{32767, -32768, -32768, 32767},                         '{32767, 32767, 32767, 32767},
      '{-32768, 0, 32767, 0},     '{320, -32768, 320, 32767}, '{320, 240, 320, 1000},
      '{640, 480, 640, 480},      '{-1, -1, -1, -1},          '{-7, 3, 13, 500},
      '{700, -20, -60, 520},      '{5, 5, 5, 5},              '{639, -1, 640, 0},
      '{-32768, 32767, 32767, -32768},                         '{600, 470, 650, 490}
   };

   initial begin
      segment_type s;
      int          x_lo, y_lo;

      // Every input of the block is known from time zero.
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.end_x = '0;
      req_bus.end_y = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = lswc_pkg::CSR_X_MIN;
      csr_bus.data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, under the window the block comes out of reset with.
      sink_mode = SINK_RANDOM;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         s.start_x = COORD_WIDTH'(directed_cases[i][0]);
         s.start_y = COORD_WIDTH'(directed_cases[i][1]);
         s.end_x = COORD_WIDTH'(directed_cases[i][2]);
         s.end_y = COORD_WIDTH'(directed_cases[i][3]);
         offer_segment(s, 1'b1);
      end
      wait_for_results();

      // Reset window written explicitly. The receiver holds off for a long stretch right away,
      // so the block backs up and stalls the request side while the sender keeps offering.
      set_window(lswc_pkg::WIN_X_MIN_RESET, lswc_pkg::WIN_X_MAX_RESET,
                 lswc_pkg::WIN_Y_MIN_RESET, lswc_pkg::WIN_Y_MAX_RESET);
      sink_mode = SINK_PATTERN;
      holdoff_requests++;
      run_random(150, 1'b1);
      wait_for_results();

      // Full coordinate range: nothing is ever clipped. No idling on either side here.
      set_window(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
      sink_mode = SINK_STEADY;
      run_random(60, 1'b0);
      wait_for_results();

      // Small window around the origin, with plenty of clipping on every edge.
      set_window(-100, 100, -50, 50);
      sink_mode = SINK_RANDOM;
      run_random(150, 1'b1);
      wait_for_results();

      // Inverted window: min above max on both axes, so every segment is rejected.
      set_window(100, -100, 50, -50);
      sink_mode = SINK_PATTERN;
      run_random(60, 1'b1);
      wait_for_results();

      // Window shrunk to a single point.
      set_window(5, 5, -7, -7);
      sink_mode = SINK_RANDOM;
      run_random(60, 1'b1);
      wait_for_results();

      // Single-point window in the extreme corner of the coordinate range.
      set_window(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
      sink_mode = SINK_STEADY;
      run_random(40, 1'b1);
      wait_for_results();

      // Random proper windows of varied size and position.
      for (int w = 0; w < 3; w++) begin
         x_lo = int'($urandom_range(0, 65535)) + COORD_MIN;
         y_lo = int'($urandom_range(0, 65535)) + COORD_MIN;
         set_window(x_lo, x_lo + int'($urandom_range(0, 3000)),
                    y_lo, y_lo + int'($urandom_range(0, 3000)));
         sink_mode = (w == 1) ? SINK_PATTERN : SINK_RANDOM;
         run_random(90, 1'b1);
         wait_for_results();
      end

      // A write to an index past the last register must leave the window unchanged.
      write_window_reg(lswc_pkg::CSR_INDEX_WIDTH'(
                          $urandom_range(int'(lswc_pkg::CSR_Y_MAX) + 1,
                                         2 ** lswc_pkg::CSR_INDEX_WIDTH - 1)),
                       int'($urandom_range(0, 65535)) + COORD_MIN);
      sink_mode = SINK_RANDOM;
      run_random(40, 1'b1);
      wait_for_results();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("line_segment_window_clipper test passed");
      end else begin
         $display("line_segment_window_clipper test failed");
      end
      $finish;
   end

endmodule
